// File: rtl/rpc_frame_deframer_core_defines.svh
// ----------------------------------------------------------------------------
// rpc frame deframer assertion macros
// shared concurrent assertion wrappers clocked on clk_i
// ----------------------------------------------------------------------------
`ifndef RPC_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define RPC_FRAME_DEFRAMER_CORE_DEFINES_SVH

// checked only while out of reset
`define RFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define RFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/rfd_pkg.sv
// ----------------------------------------------------------------------------
// rfd_pkg
// types and constants shared by the rpc frame deframer
// ----------------------------------------------------------------------------
package rfd_pkg;

  localparam int unsigned TDATA_OUT_W = 176;
  localparam int unsigned MAX_W       = 31;

  // header byte counts at which words complete
  localparam logic [4:0] CNT_SECTION = 5'd4;
  localparam logic [4:0] CNT_BYPASS  = 5'd8;
  localparam logic [4:0] CNT_TYPE    = 5'd12;
  localparam logic [4:0] CNT_ID      = 5'd16;
  localparam logic [4:0] CNT_FULL    = 5'd20;

  localparam logic [31:0] METHOD_WORD_BYTES = 32'd4;
  localparam logic [33:0] HDR_WORD_BYTES    = 34'd16;
  localparam logic [MAX_W-1:0] MAX_RESET    = 31'h7FFF_FFFF;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_METHOD  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_BYPASS  = 2'd3
  } rfd_phase_e;

  typedef enum logic [2:0] {
    KIND_HEADER  = 3'd0,
    KIND_METHOD  = 3'd1,
    KIND_PAYLOAD = 3'd2,
    KIND_BYPASS  = 3'd3,
    KIND_ERROR   = 3'd4
  } rfd_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_TOO_LARGE = 2'd1,
    ERR_SECTION   = 2'd2,
    ERR_METHOD    = 2'd3
  } rfd_err_e;

  typedef struct packed {
    rfd_kind_e   kind;
    logic [7:0]  data_byte;
    logic [31:0] msg_type;
    logic [31:0] request_id;
    logic [31:0] method_length;
    logic [31:0] payload_length;
    logic [31:0] bypass_length;
    rfd_err_e    error_code;
    logic        last;
  } rfd_result_t;

  // queue handshake between front and back
  typedef struct packed {
    logic valid;
    logic full;
  } rfd_q_status_t;

endpackage

// File: rtl/rfd_front.sv
// ----------------------------------------------------------------------------
// rfd_front
// header parser and body byte classifier, one byte per cycle while in_fire_i is high
// ----------------------------------------------------------------------------
module rfd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [30:0]          cfg_wdata_i,
  input  logic                 in_fire_i,
  input  logic [7:0]           rx_byte_i,
  output logic                 push_o,
  output rfd_pkg::rfd_result_t push_data_o
);
  import rfd_pkg::*;

  logic [MAX_W-1:0] max_q;
  rfd_phase_e       phase_q, phase_d;
  logic [4:0]       header_count_q, header_count_d;
  logic [31:0]      word_shift_q, word_shift_d;
  logic [31:0]      section_q, section_d;
  logic [31:0]      bypass_total_q, bypass_total_d;
  logic [31:0]      type_q, type_d;
  logic [31:0]      id_q, id_d;
  logic [31:0]      method_left_q, method_left_d;
  logic [31:0]      payload_left_q, payload_left_d;
  logic [31:0]      bypass_left_q, bypass_left_d;

  logic [31:0] shift_next;
  logic [4:0]  cnt_next;
  logic [33:0] total;
  logic [31:0] pay_calc;
  rfd_phase_e  hdr_phase;
  rfd_phase_e  body_phase;

  function automatic rfd_phase_e pick_phase(logic [31:0] m, logic [31:0] p, logic [31:0] b);
    rfd_phase_e ph;
    if (m != 32'd0) begin
      ph = PH_METHOD;
    end else if (p != 32'd0) begin
      ph = PH_PAYLOAD;
    end else if (b != 32'd0) begin
      ph = PH_BYPASS;
    end else begin
      ph = PH_HEADER;
    end
    return ph;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q          <= MAX_RESET;
      phase_q        <= PH_HEADER;
      header_count_q <= '0;
      word_shift_q   <= '0;
      section_q      <= '0;
      bypass_total_q <= '0;
      type_q         <= '0;
      id_q           <= '0;
      method_left_q  <= '0;
      payload_left_q <= '0;
      bypass_left_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      phase_q        <= phase_d;
      header_count_q <= header_count_d;
      word_shift_q   <= word_shift_d;
      section_q      <= section_d;
      bypass_total_q <= bypass_total_d;
      type_q         <= type_d;
      id_q           <= id_d;
      method_left_q  <= method_left_d;
      payload_left_q <= payload_left_d;
      bypass_left_q  <= bypass_left_d;
    end
  end

  assign shift_next = {word_shift_q[23:0], rx_byte_i};
  assign cnt_next   = header_count_q + 5'd1;
  assign total      = HDR_WORD_BYTES + {2'b00, section_q} + {2'b00, shift_next};
  assign pay_calc   = section_q - METHOD_WORD_BYTES - shift_next;
  assign hdr_phase  = pick_phase(shift_next, pay_calc, bypass_total_q);

  always_comb begin
    phase_d        = phase_q;
    header_count_d = header_count_q;
    word_shift_d   = word_shift_q;
    section_d      = section_q;
    bypass_total_d = bypass_total_q;
    type_d         = type_q;
    id_d           = id_q;
    method_left_d  = method_left_q;
    payload_left_d = payload_left_q;
    bypass_left_d  = bypass_left_q;
    push_o         = 1'b0;
    push_data_o    = '0;
    body_phase     = phase_q;

    if (in_fire_i) begin
      if (phase_q == PH_HEADER) begin
        word_shift_d   = shift_next;
        header_count_d = cnt_next;
        case (cnt_next)
          CNT_SECTION: section_d = shift_next;
          CNT_BYPASS: begin
            bypass_total_d = shift_next;
            if (total > {3'b000, max_q}) begin
              push_o                 = 1'b1;
              push_data_o.kind       = KIND_ERROR;
              push_data_o.error_code = ERR_TOO_LARGE;
              push_data_o.last       = 1'b1;
              header_count_d         = '0;
            end else if (section_q < METHOD_WORD_BYTES) begin
              push_o                 = 1'b1;
              push_data_o.kind       = KIND_ERROR;
              push_data_o.error_code = ERR_SECTION;
              push_data_o.last       = 1'b1;
              header_count_d         = '0;
            end
          end
          CNT_TYPE: type_d = shift_next;
          CNT_ID:   id_d   = shift_next;
          CNT_FULL: begin
            push_o         = 1'b1;
            header_count_d = '0;
            if (({1'b0, shift_next} + {1'b0, METHOD_WORD_BYTES}) > {1'b0, section_q}) begin
              push_data_o.kind       = KIND_ERROR;
              push_data_o.error_code = ERR_METHOD;
              push_data_o.last       = 1'b1;
            end else begin
              method_left_d              = shift_next;
              payload_left_d             = pay_calc;
              bypass_left_d              = bypass_total_q;
              phase_d                    = hdr_phase;
              push_data_o.kind           = KIND_HEADER;
              push_data_o.msg_type       = type_q;
              push_data_o.request_id     = id_q;
              push_data_o.method_length  = shift_next;
              push_data_o.payload_length = pay_calc;
              push_data_o.bypass_length  = bypass_total_q;
              push_data_o.last           = (hdr_phase == PH_HEADER);
            end
          end
          default: begin
            if (cnt_next > CNT_FULL) begin
              header_count_d = '0;
            end
          end
        endcase
      end else begin
        case (phase_q)
          PH_METHOD: begin
            if (method_left_q != 32'd0) method_left_d = method_left_q - 32'd1;
          end
          PH_PAYLOAD: begin
            if (payload_left_q != 32'd0) payload_left_d = payload_left_q - 32'd1;
          end
          PH_BYPASS: begin
            if (bypass_left_q != 32'd0) bypass_left_d = bypass_left_q - 32'd1;
          end
          default: ;
        endcase
        body_phase            = pick_phase(method_left_d, payload_left_d, bypass_left_d);
        phase_d               = body_phase;
        push_o                = 1'b1;
        push_data_o.kind      = rfd_kind_e'({1'b0, phase_q});
        push_data_o.data_byte = rx_byte_i;
        push_data_o.last      = (body_phase == PH_HEADER);
      end
    end
  end

endmodule

// File: rtl/rfd_queue.sv
// ----------------------------------------------------------------------------
// rfd_queue
// short result queue between the parser and the output stage
// ----------------------------------------------------------------------------
module rfd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  rfd_pkg::rfd_result_t  push_data_i,
  input  logic                  pop_i,
  output rfd_pkg::rfd_q_status_t status_o,
  output rfd_pkg::rfd_result_t  head_o
);
  import rfd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  rfd_result_t      entries_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    if (p == PTR_W'(DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + PTR_W'(1);
    end
    return n;
  endfunction

  assign status_o.valid = (count_q != '0);
  assign status_o.full  = (count_q == CNT_W'(DEPTH));
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && status_o.valid;
  assign head_o         = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + CNT_W'(1);
        2'b01:   count_q <= count_q - CNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// File: rtl/rfd_back.sv
// ----------------------------------------------------------------------------
// rfd_back
// output register stage, drains the queue onto the result stream
// ----------------------------------------------------------------------------
module rfd_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rfd_pkg::rfd_q_status_t status_i,
  input  rfd_pkg::rfd_result_t   head_i,
  output logic                   pop_o,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [rfd_pkg::TDATA_OUT_W-1:0] m_axis_tdata_o,
  output logic [2:0]             m_axis_tuser_o,
  output logic                   m_axis_tlast_o
);
  import rfd_pkg::*;

  logic        out_valid_q;
  rfd_result_t out_q;

  assign pop_o = status_i.valid && (!out_valid_q || m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready_i) begin
      out_valid_q <= status_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= head_i;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tlast_o  = out_q.last;
  assign m_axis_tdata_o  = {6'd0, out_q.error_code, out_q.bypass_length,
                            out_q.payload_length, out_q.method_length,
                            out_q.request_id, out_q.msg_type, out_q.data_byte};

endmodule

// File: rtl/rpc_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// rpc_frame_deframer_core
// splits a byte stream into length-prefixed rpc frames and tags body bytes
//
//   channel   dir  content
//   s_axis    in   tdata: rx_byte[7:0]
//   m_axis    out  tdata: data_byte, msg_type, request_id, method_length,
//                  payload_length, bypass_length, error_code; tuser: kind;
//                  tlast: last
//   cfg       in   cfg_wdata_i: max_frame_bytes
//
// one byte per cycle sustained while the queue has room; a result passes
// through the queue register and then the output register
// reset sets max_frame_bytes to its largest value and starts in the header
// a stalled output fills the queue (QUEUE_DEPTH results), then input stalls
// ----------------------------------------------------------------------------
`include "rpc_frame_deframer_core_defines.svh"

module rpc_frame_deframer_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [30:0]  cfg_wdata_i,     // max_frame_bytes
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,  // rx_byte[7:0]
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // data_byte[7:0] msg_type[39:8] request_id[71:40] method_length[103:72]
  // payload_length[135:104] bypass_length[167:136] error_code[169:168]
  output logic [175:0] m_axis_tdata_o,
  output logic [2:0]   m_axis_tuser_o,  // kind[2:0]
  output logic         m_axis_tlast_o
);
  import rfd_pkg::*;

  logic           in_fire;
  logic           push;
  rfd_result_t    push_data;
  logic           pop;
  rfd_q_status_t  q_status;
  rfd_result_t    q_head;

  assign s_axis_tready_o = !q_status.full;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  rfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_fire_i   (in_fire),
    .rx_byte_i   (s_axis_tdata_i),
    .push_o      (push),
    .push_data_o (push_data)
  );

  rfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .status_o    (q_status),
    .head_o      (q_head)
  );

  rfd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .status_i        (q_status),
    .head_i          (q_head),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // error results close the frame with a code; other kinds carry none
  `RFD_ASSERT(a_err_last, m_axis_tvalid_o && (m_axis_tuser_o == KIND_ERROR) |-> m_axis_tlast_o && (m_axis_tdata_o[169:168] != ERR_NONE), "error result without last or code")
  `RFD_ASSERT(a_err_code_kind, m_axis_tvalid_o && (m_axis_tuser_o != KIND_ERROR) |-> (m_axis_tdata_o[169:168] == ERR_NONE), "error code on non-error result")
  // input is held off only while results are waiting in the queue
  `RFD_ASSERT_ALWAYS(a_ready_queue, !s_axis_tready_o |-> q_status.valid, "input stalled with empty queue")
  `RFD_ASSERT(a_hdr_no_byte, m_axis_tvalid_o && ((m_axis_tuser_o == KIND_HEADER) || (m_axis_tuser_o == KIND_ERROR)) |-> (m_axis_tdata_o[7:0] == 8'd0), "data byte on header or error result")

endmodule

// File: sim/rpc_frame_deframer_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rpc_frame_deframer_core_tb
// drives length-prefixed rpc frames through the deframer and checks every
// header, body-byte and error result against a built-in frame parser, with
// random gaps on the input, random backpressure and changes of the frame limit
// ----------------------------------------------------------------------------
module rpc_frame_deframer_core_tb;
  import rfd_pkg::*;

  localparam int RANDOM_END  = 1450;
  localparam int TOTAL_BYTES = 1650;
  localparam int CYCLE_LIMIT = 500000;

  logic         clk_i;
  logic         rst_ni    = 1'b0;
  logic         cfg_we    = 1'b0;
  logic [30:0]  cfg_wdata = '0;
  logic         s_tvalid  = 1'b0;
  logic [7:0]   s_tdata   = '0;
  logic         m_tready  = 1'b0;
  logic         s_axis_tready_o;
  logic         m_axis_tvalid_o;
  logic [175:0] m_axis_tdata_o;
  logic [2:0]   m_axis_tuser_o;
  logic         m_axis_tlast_o;

  // parser state mirrored from the block
  rfd_phase_e   cur_phase = PH_HEADER;
  logic [4:0]   hdr_count = '0;
  logic [31:0]  word_acc  = '0;
  logic [31:0]  sect_len  = '0;
  logic [31:0]  byp_total = '0;
  logic [31:0]  type_word = '0;
  logic [31:0]  id_word   = '0;
  logic [31:0]  meth_left = '0;
  logic [31:0]  pay_left  = '0;
  logic [31:0]  byp_left  = '0;
  logic [30:0]  max_bytes = MAX_RESET;

  rfd_result_t  frame_results_q[$];
  int           bytes_sent     = 0;
  int           mismatch_count = 0;
  int           cycle_count    = 0;
  bit           src_gaps       = 1'b1;
  bit           sink_gaps      = 1'b1;

  rpc_frame_deframer_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------- parser

  function automatic void pick_phase();
    if (meth_left != 0) cur_phase = PH_METHOD;
    else if (pay_left != 0) cur_phase = PH_PAYLOAD;
    else if (byp_left != 0) cur_phase = PH_BYPASS;
    else cur_phase = PH_HEADER;
  endfunction

  function automatic void abort_frame(output rfd_result_t r, input rfd_err_e code);
    r            = '0;
    r.kind       = KIND_ERROR;
    r.error_code = code;
    r.last       = 1'b1;
    cur_phase    = PH_HEADER;
    hdr_count    = '0;
  endfunction

  function automatic bit at_boundary();
    return cur_phase == PH_HEADER && hdr_count == 5'd0;
  endfunction

  // returns 1 when the byte produces a result
  function automatic bit deframe_byte(input logic [7:0] b, output rfd_result_t r);
    logic [33:0] sum;
    r = '0;
    if (cur_phase == PH_HEADER) begin
      word_acc  = {word_acc[23:0], b};
      hdr_count = hdr_count + 5'd1;
      case (hdr_count)
        CNT_SECTION: sect_len = word_acc;
        CNT_BYPASS: begin
          byp_total = word_acc;
          sum = HDR_WORD_BYTES + {2'b00, sect_len} + {2'b00, byp_total};
          if (sum > {3'b000, max_bytes}) begin
            abort_frame(r, ERR_TOO_LARGE);
            return 1'b1;
          end
          if (sect_len < METHOD_WORD_BYTES) begin
            abort_frame(r, ERR_SECTION);
            return 1'b1;
          end
        end
        CNT_TYPE: type_word = word_acc;
        CNT_ID:   id_word = word_acc;
        CNT_FULL: begin
          sum = {2'b00, METHOD_WORD_BYTES} + {2'b00, word_acc};
          if (sum > {2'b00, sect_len}) begin
            abort_frame(r, ERR_METHOD);
            return 1'b1;
          end
          meth_left = word_acc;
          pay_left  = sect_len - METHOD_WORD_BYTES - word_acc;
          byp_left  = byp_total;
          hdr_count = '0;
          pick_phase();
          r.kind           = KIND_HEADER;
          r.msg_type       = type_word;
          r.request_id     = id_word;
          r.method_length  = meth_left;
          r.payload_length = pay_left;
          r.bypass_length  = byp_left;
          r.last           = (cur_phase == PH_HEADER);
          return 1'b1;
        end
        default: if (hdr_count > CNT_FULL) hdr_count = '0;
      endcase
      return 1'b0;
    end
    r.kind      = rfd_kind_e'({1'b0, cur_phase});
    r.data_byte = b;
    if (cur_phase == PH_METHOD && meth_left != 0) meth_left--;
    else if (cur_phase == PH_PAYLOAD && pay_left != 0) pay_left--;
    else if (cur_phase == PH_BYPASS && byp_left != 0) byp_left--;
    pick_phase();
    r.last = (cur_phase == PH_HEADER);
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 100) $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk_i) begin : result_check
    rfd_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      if (frame_results_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, kind %0d", m_axis_tuser_o));
      end else begin
        want = frame_results_q.pop_front();
        check_field("kind", 32'(m_axis_tuser_o), 32'(want.kind));
        check_field("data_byte", 32'(m_axis_tdata_o[7:0]), 32'(want.data_byte));
        check_field("msg_type", m_axis_tdata_o[39:8], want.msg_type);
        check_field("request_id", m_axis_tdata_o[71:40], want.request_id);
        check_field("method_length", m_axis_tdata_o[103:72], want.method_length);
        check_field("payload_length", m_axis_tdata_o[135:104], want.payload_length);
        check_field("bypass_length", m_axis_tdata_o[167:136], want.bypass_length);
        check_field("error_code", 32'(m_axis_tdata_o[169:168]), 32'(want.error_code));
        check_field("last", 32'(m_axis_tlast_o), 32'(want.last));
      end
    end
  end

  // output backpressure in bursts
  initial begin : sink_stall
    int n;
    wait (rst_ni);
    forever begin
      if (sink_gaps && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 19);
        m_tready <= 1'b0;
      end else begin
        n = $urandom_range(1, 12);
        m_tready <= 1'b1;
      end
      repeat (n) @(posedge clk_i);
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send_byte(input logic [7:0] b);
    rfd_result_t r;
    if (src_gaps && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (deframe_byte(b, r)) frame_results_q.push_back(r);
    bytes_sent++;
  endtask

  // sends header and body; stops early once the parser is back at a frame start
  task automatic send_frame(input logic [31:0] sect, input logic [31:0] byp,
                            input logic [31:0] mtype, input logic [31:0] rid,
                            input logic [31:0] mlen, input int fill = -1);
    logic [31:0] words [0:4];
    words = '{sect, byp, mtype, rid, mlen};
    for (int i = 0; i < 20; i++) begin
      send_byte(words[i / 4][31 - 8 * (i % 4) -: 8]);
      if (at_boundary()) return;
    end
    while (!at_boundary())
      send_byte((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_max_frame(input logic [30:0] v);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    max_bytes = v;
  endtask

  task automatic send_random_frame(input bit allow_noise);
    logic [31:0] sect, byp, mtype, rid, mlen;
    int pick;
    pick  = $urandom_range(0, 99);
    mtype = ($urandom_range(0, 7) == 0) ? '1 : $urandom();
    rid   = ($urandom_range(0, 7) == 0) ? '0 : $urandom();
    mlen  = $urandom_range(0, 5);
    sect  = 4 + mlen + (($urandom_range(0, 9) == 0) ? $urandom_range(20, 48)
                                                    : $urandom_range(0, 8));
    byp   = $urandom_range(0, 5);
    if (pick < 70) begin
    end else if (pick < 78) begin
      sect = $urandom_range(0, 3);
    end else if (pick < 86) begin
      mlen = ($urandom_range(0, 3) == 0) ? ($urandom() | 32'h8000_0000)
                                         : sect - 3 + $urandom_range(0, 6);
    end else if (pick < 92) begin
      byp = $urandom() | 32'h8000_0000;
    end else if (allow_noise) begin
      // garbage bytes, then whatever it takes to get back to a frame start
      repeat ($urandom_range(1, 30)) send_byte(8'($urandom_range(0, 255)));
      while (!at_boundary()) send_byte(8'($urandom_range(0, 255)));
      return;
    end
    send_frame(sect, byp, mtype, rid, mlen);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_frame_layout();
    send_frame(32'd4, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0);           // empty body
    send_frame(32'd6, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'd1, 8'hFF);     // one of each
    send_frame(32'd7, 32'd0, 32'h1234_5678, 32'h9ABC_DEF0, 32'd3, 8'h00);
    send_frame(32'd8, 32'd2, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'd4);   // no payload
    send_frame(32'd5, 32'd3, 32'd1, 32'd2, 32'd0);                   // payload and bypass, no method
  endtask

  task automatic test_header_errors();
    send_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);   // sum must not wrap
    send_frame(32'h7FFF_FFF0, 32'd0, 32'd0, 32'd0, 32'd0);           // one over the limit
    send_frame(32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);           // size error wins
    send_frame(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_frame(32'd3, 32'd2, 32'd0, 32'd0, 32'd0);
    send_frame(32'd8, 32'd0, 32'd7, 32'd9, 32'd5);                   // method overruns
    send_frame(32'd8, 32'd1, 32'd7, 32'd9, 32'hFFFF_FFFF);
  endtask

  task automatic test_limit_register();
    write_max_frame(31'd20);
    send_frame(32'd4, 32'd0, 32'd1, 32'd2, 32'd0);                   // exactly at the limit
    send_frame(32'd4, 32'd1, 32'd1, 32'd2, 32'd0);
    write_max_frame(31'd0);
    send_frame(32'd4, 32'd0, 32'd3, 32'd4, 32'd0);
    write_max_frame(31'd19);
    send_frame(32'd4, 32'd0, 32'd3, 32'd4, 32'd0);
    write_max_frame(MAX_RESET);
    send_frame(32'd9, 32'd2, 32'd5, 32'd6, 32'd2);
  endtask

  task automatic test_random_frames();
    logic [30:0] limit;
    int phase_end;
    while (bytes_sent < RANDOM_END) begin
      case ($urandom_range(0, 9))
        0, 1, 2: limit = MAX_RESET;
        3, 4, 5: limit = 31'($urandom_range(20, 90));
        6:       limit = 31'($urandom_range(0, 19));
        7:       limit = 31'd20;
        default: limit = 31'($urandom());
      endcase
      write_max_frame(limit);
      phase_end = bytes_sent + $urandom_range(120, 260);
      while (bytes_sent < phase_end) begin
        send_random_frame(limit <= 31'd1000);
        if ($urandom_range(0, 30) == 0) drain_results();
      end
    end
  endtask

  task automatic test_full_rate();
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    write_max_frame(MAX_RESET);
    while (bytes_sent < TOTAL_BYTES) send_random_frame(1'b0);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_frame_layout();
    test_header_errors();
    test_limit_register();
    test_random_frames();
    test_full_rate();
    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
